[rtl/ckpf_pkg.sv]
// ----------------------------------------------------------------------------
// ckpf_pkg
// Shared types and constants for the color key pattern fill block: command
// codes, configuration register indexes, field widths and default sizes.
// ----------------------------------------------------------------------------
package ckpf_pkg;

  // Default number of patterns and default pattern side in texels.
  localparam int unsigned NumPatternsDefault = 4;
  localparam int unsigned PatternSideDefault = 64;

  // Number of key color registers.
  localparam int unsigned KeyRegs = 4;

  // Field widths fixed by the interface.
  localparam int unsigned PixelW   = 64;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned SelW     = 2;
  localparam int unsigned SizeInW  = 7;
  localparam int unsigned TexPosW  = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned InUseW   = 3;

  // Item commands.
  typedef enum logic [CmdW-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_SIZE  = 2'd1,
    CMD_TEXEL = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_COLOR_0     = 3'd0,
    CFG_KEY_COLOR_1     = 3'd1,
    CFG_KEY_COLOR_2     = 3'd2,
    CFG_KEY_COLOR_3     = 3'd3,
    CFG_PATTERNS_IN_USE = 3'd4,
    CFG_FRAME_WIDTH     = 3'd5,
    CFG_FRAME_HEIGHT    = 3'd6
  } cfg_idx_e;

endpackage

[rtl/color_key_pattern_fill.sv]
// ----------------------------------------------------------------------------
// color_key_pattern_fill
// Replaces pixels that match one of up to four key colors with a texel of
// that key's tiled pattern, tracking frame and tile positions in raster order.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  --------------------------------
// in        input      in_valid_i / in_stall_o    command, pixel, pattern select,
//                                                 pattern size, texel position
// out       output     out_valid_o / out_stall_i  pixel_out, substituted,
//                                                 pattern_hit, end_of_row,
//                                                 end_of_frame, status
// cfg       input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// At acceptance an item issues its texel memory access, the middle stage
// then holds the registered read data, and the output register follows.
// One item is accepted in every cycle while the output side takes results;
// the single read/write port of the texel memory is used at most once per item.
// Reset clears the position counters, tile sizes and configuration registers;
// the texel memory is not cleared, so a pattern must be written before use.
// When the output stalls, the middle stage and the output register hold two
// items; once both are full, in_stall_o rises in the same cycle as the stall.
//
module color_key_pattern_fill #(
  parameter int unsigned NUM_PATTERNS = ckpf_pkg::NumPatternsDefault,
  parameter int unsigned PATTERN_SIDE = ckpf_pkg::PatternSideDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [ckpf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ckpf_pkg::PixelW-1:0]   cfg_wdata_i,

  // Input items.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ckpf_pkg::CmdW-1:0]     command_i,
  input  logic [ckpf_pkg::PixelW-1:0]   pixel_value_i,
  input  logic [ckpf_pkg::SelW-1:0]     pattern_select_i,
  input  logic [ckpf_pkg::SizeInW-1:0]  pattern_width_i,
  input  logic [ckpf_pkg::SizeInW-1:0]  pattern_height_i,
  input  logic [ckpf_pkg::TexPosW-1:0]  texel_column_i,
  input  logic [ckpf_pkg::TexPosW-1:0]  texel_row_i,

  // Result items.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ckpf_pkg::PixelW-1:0]   pixel_out_o,
  output logic                          substituted_o,
  output logic [ckpf_pkg::SelW-1:0]     pattern_hit_o,
  output logic                          end_of_row_o,
  output logic                          end_of_frame_o,
  output logic                          status_o
);

  // Derived sizes. Tile positions run below PATTERN_SIDE; tile sizes reach it.
  localparam int unsigned PlaneSize = PATTERN_SIDE * PATTERN_SIDE;
  localparam int unsigned MemDepth  = NUM_PATTERNS * PlaneSize;
  localparam int unsigned AddrW     = $clog2(MemDepth);
  localparam int unsigned PosW      = $clog2(PATTERN_SIDE);
  localparam int unsigned SizeW     = $clog2(PATTERN_SIDE + 1);
  localparam int unsigned ActiveMax = (NUM_PATTERNS < ckpf_pkg::KeyRegs) ?
                                      NUM_PATTERNS : ckpf_pkg::KeyRegs;
  localparam int unsigned PW  = ckpf_pkg::PixelW;
  localparam int unsigned FW  = ckpf_pkg::FrameW;
  localparam int unsigned SW  = ckpf_pkg::SelW;
  localparam int unsigned IUW = ckpf_pkg::InUseW;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [PW-1:0]  key_color_q [ckpf_pkg::KeyRegs];
  logic [IUW-1:0] in_use_q;
  logic [FW-1:0]  frame_width_q;
  logic [FW-1:0]  frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ckpf_pkg::KeyRegs; k++) begin
        key_color_q[k] <= '0;
      end
      in_use_q       <= '0;
      frame_width_q  <= FW'(1);
      frame_height_q <= FW'(1);
    end else if (cfg_we_i) begin
      case (ckpf_pkg::cfg_idx_e'(cfg_index_i))
        ckpf_pkg::CFG_KEY_COLOR_0:     key_color_q[0] <= cfg_wdata_i;
        ckpf_pkg::CFG_KEY_COLOR_1:     key_color_q[1] <= cfg_wdata_i;
        ckpf_pkg::CFG_KEY_COLOR_2:     key_color_q[2] <= cfg_wdata_i;
        ckpf_pkg::CFG_KEY_COLOR_3:     key_color_q[3] <= cfg_wdata_i;
        ckpf_pkg::CFG_PATTERNS_IN_USE: in_use_q       <= cfg_wdata_i[IUW-1:0];
        ckpf_pkg::CFG_FRAME_WIDTH:     frame_width_q  <= cfg_wdata_i[FW-1:0];
        ckpf_pkg::CFG_FRAME_HEIGHT:    frame_height_q <= cfg_wdata_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // The number of key and pattern pairs that take part in matching.
  logic [IUW-1:0] active_n;
  assign active_n = (32'(in_use_q) > ActiveMax) ? IUW'(ActiveMax) : in_use_q;

  // --------------------------------------------------------------------------
  // Handshake and pipeline control.
  // --------------------------------------------------------------------------
  logic s1_valid_q, out_valid_q;
  logic s1_advance, in_accept;

  // The middle stage moves on when the output register is empty or drained.
  assign s1_advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Item decode.
  // --------------------------------------------------------------------------
  logic is_pixel, is_size, is_texel, sel_ok, texel_in_range;

  always_comb begin
    is_pixel = 1'b0;
    is_size  = 1'b0;
    is_texel = 1'b0;
    case (ckpf_pkg::cmd_e'(command_i))
      ckpf_pkg::CMD_PIXEL: is_pixel = 1'b1;
      ckpf_pkg::CMD_SIZE:  is_size  = 1'b1;
      ckpf_pkg::CMD_TEXEL: is_texel = 1'b1;
      default: ;
    endcase
  end

  assign sel_ok         = {1'b0, pattern_select_i} < active_n;
  assign texel_in_range = (32'(texel_column_i) < PATTERN_SIDE) &&
                          (32'(texel_row_i) < PATTERN_SIDE);

  logic do_size, do_texel, reject;
  assign do_size  = is_size && sel_ok;
  assign do_texel = is_texel && sel_ok && texel_in_range;
  assign reject   = !is_pixel && !do_size && !do_texel;

  // --------------------------------------------------------------------------
  // Frame position counters.
  // --------------------------------------------------------------------------
  logic [FW-1:0] frame_col_q, frame_row_q, frame_col_d, frame_row_d;
  logic [FW-1:0] fw_eff, fh_eff;
  logic          eor, eof;

  assign fw_eff = (frame_width_q == '0) ? FW'(1) : frame_width_q;
  assign fh_eff = (frame_height_q == '0) ? FW'(1) : frame_height_q;
  // A counter at or past the last position after the size was lowered
  // counts as the last position.
  assign eor = ((FW+1)'(frame_col_q) + (FW+1)'(1)) >= (FW+1)'(fw_eff);
  assign eof = eor && (((FW+1)'(frame_row_q) + (FW+1)'(1)) >= (FW+1)'(fh_eff));

  always_comb begin
    frame_col_d = frame_col_q;
    frame_row_d = frame_row_q;
    if (in_accept && is_pixel) begin
      if (eor) begin
        frame_col_d = '0;
        frame_row_d = eof ? '0 : frame_row_q + FW'(1);
      end else begin
        frame_col_d = frame_col_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_col_q <= '0;
      frame_row_q <= '0;
    end else begin
      frame_col_q <= frame_col_d;
      frame_row_q <= frame_row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Tile sizes and wrapping tile position counters, one set per pattern.
  // --------------------------------------------------------------------------
  logic [SizeW-1:0] tile_w_q [NUM_PATTERNS];
  logic [SizeW-1:0] tile_h_q [NUM_PATTERNS];
  logic [PosW-1:0]  tile_c_q [NUM_PATTERNS];
  logic [PosW-1:0]  tile_r_q [NUM_PATTERNS];
  logic [SizeW-1:0] tile_w_d [NUM_PATTERNS];
  logic [SizeW-1:0] tile_h_d [NUM_PATTERNS];
  logic [PosW-1:0]  tile_c_d [NUM_PATTERNS];
  logic [PosW-1:0]  tile_r_d [NUM_PATTERNS];
  logic [SizeW-1:0] new_w, new_h;

  // A size of zero becomes one; a size beyond the pattern side saturates.
  always_comb begin
    if (pattern_width_i == '0) begin
      new_w = SizeW'(1);
    end else if (32'(pattern_width_i) > PATTERN_SIDE) begin
      new_w = SizeW'(PATTERN_SIDE);
    end else begin
      new_w = SizeW'(pattern_width_i);
    end
    if (pattern_height_i == '0) begin
      new_h = SizeW'(1);
    end else if (32'(pattern_height_i) > PATTERN_SIDE) begin
      new_h = SizeW'(PATTERN_SIDE);
    end else begin
      new_h = SizeW'(pattern_height_i);
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      tile_w_d[p] = tile_w_q[p];
      tile_h_d[p] = tile_h_q[p];
      tile_c_d[p] = tile_c_q[p];
      tile_r_d[p] = tile_r_q[p];
      if (in_accept && is_pixel) begin
        if (eor) begin
          tile_c_d[p] = '0;
          if (eof || (SizeW'(tile_r_q[p]) + SizeW'(1) >= tile_h_q[p])) begin
            tile_r_d[p] = '0;
          end else begin
            tile_r_d[p] = tile_r_q[p] + PosW'(1);
          end
        end else if (SizeW'(tile_c_q[p]) + SizeW'(1) >= tile_w_q[p]) begin
          tile_c_d[p] = '0;
        end else begin
          tile_c_d[p] = tile_c_q[p] + PosW'(1);
        end
      end else if (in_accept && do_size && ({1'b0, pattern_select_i} == 3'(p))) begin
        // A new size restarts the tiling phase of that pattern.
        tile_w_d[p] = new_w;
        tile_h_d[p] = new_h;
        tile_c_d[p] = '0;
        tile_r_d[p] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        tile_w_q[p] <= SizeW'(1);
        tile_h_q[p] <= SizeW'(1);
        tile_c_q[p] <= '0;
        tile_r_q[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        tile_w_q[p] <= tile_w_d[p];
        tile_h_q[p] <= tile_h_d[p];
        tile_c_q[p] <= tile_c_d[p];
        tile_r_q[p] <= tile_r_d[p];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Key compare: the lowest matching index among the active keys wins.
  // --------------------------------------------------------------------------
  logic          key_found;
  logic [SW-1:0] key_hit;

  always_comb begin
    key_found = 1'b0;
    key_hit   = '0;
    for (int k = ckpf_pkg::KeyRegs - 1; k >= 0; k--) begin
      if ((IUW'(k) < active_n) && (key_color_q[k] == pixel_value_i)) begin
        key_found = 1'b1;
        key_hit   = SW'(k);
      end
    end
  end

  // Tile position of the winning pattern.
  logic [PosW-1:0] hit_col, hit_row;

  always_comb begin
    hit_col = '0;
    hit_row = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if ({1'b0, key_hit} == 3'(p)) begin
        hit_col = tile_c_q[p];
        hit_row = tile_r_q[p];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Texel memory: one write or one read per item, read data registered.
  // A write is visible to a read in the next cycle, so no forwarding is needed.
  // --------------------------------------------------------------------------
  logic [PW-1:0]    texel_mem [MemDepth];
  logic [PW-1:0]    rdata_q;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             mem_re, mem_we;

  assign rd_addr = AddrW'(32'(key_hit) * PlaneSize + 32'(hit_row) * PATTERN_SIDE +
                          32'(hit_col));
  assign wr_addr = AddrW'(32'(pattern_select_i) * PlaneSize +
                          32'(texel_row_i) * PATTERN_SIDE + 32'(texel_column_i));
  assign mem_re  = in_accept && is_pixel && key_found;
  assign mem_we  = in_accept && do_texel;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      texel_mem[wr_addr] <= pixel_value_i;
    end
    if (mem_re) begin
      rdata_q <= texel_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Middle stage: item flags wait here for the memory read data.
  // --------------------------------------------------------------------------
  logic          s1_subst_q, s1_eor_q, s1_eof_q, s1_status_q;
  logic [SW-1:0] s1_hit_q;
  logic [PW-1:0] s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_subst_q  <= is_pixel && key_found;
      s1_hit_q    <= (is_pixel && key_found) ? key_hit : '0;
      s1_eor_q    <= is_pixel && eor;
      s1_eof_q    <= is_pixel && eof;
      s1_status_q <= reject;
      s1_pix_q    <= is_pixel ? pixel_value_i : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic          out_load;
  logic          out_subst_q, out_eor_q, out_eof_q, out_status_q;
  logic [SW-1:0] out_hit_q;
  logic [PW-1:0] out_pix_q;

  assign out_load = s1_valid_q && s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q    <= s1_subst_q ? rdata_q : s1_pix_q;
      out_subst_q  <= s1_subst_q;
      out_hit_q    <= s1_hit_q;
      out_eor_q    <= s1_eor_q;
      out_eof_q    <= s1_eof_q;
      out_status_q <= s1_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = out_pix_q;
  assign substituted_o  = out_subst_q;
  assign pattern_hit_o  = out_hit_q;
  assign end_of_row_o   = out_eor_q;
  assign end_of_frame_o = out_eof_q;
  assign status_o       = out_status_q;

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for color_key_pattern_fill. A directed table covers
// reset behavior, tile size saturation, key priority and rejected commands.
// Random segments follow, each with its own key, frame and pattern setup,
// under several sender and receiver idling mixes. Every result item is
// compared field by field with an in-order prediction kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ckpf_pkg::*;

  // Command code 3 has no meaning in the block and must be rejected.
  localparam logic [CmdW-1:0]    CMD_UNKNOWN = 2'd3;
  // Register index 7 addresses no register; writes to it change nothing.
  localparam logic [CfgIdxW-1:0] CFG_SPARE   = 3'd7;

  localparam int SIDE         = PatternSideDefault;
  localparam int TEXEL_WORDS  = NumPatternsDefault * SIDE * SIDE;
  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 115;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [63:0] ONES     = '1;
  localparam logic [63:0] KEY_TWO  = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] KEY_THR  = 64'h8000_0000_0000_0001;
  localparam logic [63:0] NON_KEY  = 64'hFEDC_BA98_7654_3210;

  typedef struct packed {
    logic [PixelW-1:0]  pixel;
    logic               substituted;
    logic [SelW-1:0]    hit;
    logic               eor;
    logic               eof;
    logic               status;
  } fill_res_t;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [PixelW-1:0]  pixel;
    logic [SelW-1:0]    sel;
    logic [SizeInW-1:0] tile_wd;
    logic [SizeInW-1:0] tile_ht;
    logic [TexPosW-1:0] col;
    logic [TexPosW-1:0] row;
  } fill_item_t;

  // One line of stimulus: either a register write or an item, the latter
  // optionally carrying a hand-written result.
  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] cfg_index;
    logic [PixelW-1:0]  cfg_data;
    fill_item_t         item;
    logic               has_typed;
    fill_res_t          typed_res;
  } stim_row_t;

  localparam fill_res_t REJECTED = {64'd0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b1};
  localparam fill_res_t QUIET    = '0;

  logic                 clk_i;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i      = '0;
  logic [PixelW-1:0]    cfg_wdata_i      = '0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic [CmdW-1:0]      command_i        = '0;
  logic [PixelW-1:0]    pixel_value_i    = '0;
  logic [SelW-1:0]      pattern_select_i = '0;
  logic [SizeInW-1:0]   pattern_width_i  = '0;
  logic [SizeInW-1:0]   pattern_height_i = '0;
  logic [TexPosW-1:0]   texel_column_i   = '0;
  logic [TexPosW-1:0]   texel_row_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic [PixelW-1:0]    pixel_out_o;
  logic                 substituted_o;
  logic [SelW-1:0]      pattern_hit_o;
  logic                 end_of_row_o;
  logic                 end_of_frame_o;
  logic                 status_o;

  color_key_pattern_fill u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .pixel_value_i    (pixel_value_i),
    .pattern_select_i (pattern_select_i),
    .pattern_width_i  (pattern_width_i),
    .pattern_height_i (pattern_height_i),
    .texel_column_i   (texel_column_i),
    .texel_row_i      (texel_row_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_out_o      (pixel_out_o),
    .substituted_o    (substituted_o),
    .pattern_hit_o    (pattern_hit_o),
    .end_of_row_o     (end_of_row_o),
    .end_of_frame_o   (end_of_frame_o),
    .status_o         (status_o)
  );

  // Bench copy of the configuration and the block state.
  logic [63:0] key_cfg [4];
  logic [2:0]  in_use_cfg;
  logic [15:0] frame_w_cfg;
  logic [15:0] frame_h_cfg;
  logic [15:0] col_pos;
  logic [15:0] row_pos;
  logic [6:0]  tile_w [4];
  logic [6:0]  tile_h [4];
  logic [5:0]  tile_c [4];
  logic [5:0]  tile_r [4];
  logic [63:0] texel_copy    [TEXEL_WORDS];
  bit          texel_written [TEXEL_WORDS];

  fill_res_t   fill_due [$];
  stim_row_t   directed_rows [$];
  int          items_sent;
  int          mismatches;
  int          idle_pct;
  int          stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The run must never take anywhere near this long.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic int active_keys();
    return (in_use_cfg > NumPatternsDefault) ? NumPatternsDefault : int'(in_use_cfg);
  endfunction

  function automatic int texel_addr(int pat, int row, int col);
    return (pat * SIDE + row) * SIDE + col;
  endfunction

  function automatic logic [6:0] clamp_side(logic [6:0] v);
    if (v == 0) return 7'd1;
    if (v > SIDE) return 7'(SIDE);
    return v;
  endfunction

  // A pixel is safe to send unless the key it hits points at a texel that
  // was never loaded; the block's texel memory holds garbage there.
  function automatic bit texel_ready(logic [63:0] pix);
    for (int p = 0; p < active_keys(); p++) begin
      if (key_cfg[p] == pix) begin
        return texel_written[texel_addr(p, int'(tile_r[p]), int'(tile_c[p]))];
      end
    end
    return 1'b1;
  endfunction

  // Works out the result of one accepted item and advances the state copy.
  function automatic fill_res_t predict_fill(fill_item_t it);
    fill_res_t res;
    int        n;
    int        fw;
    int        fh;
    logic      eor;
    logic      eof;
    logic      found;
    int        addr;
    res   = '0;
    n     = active_keys();
    found = 1'b0;
    if (it.cmd == CMD_PIXEL) begin
      fw  = (frame_w_cfg == 0) ? 1 : int'(frame_w_cfg);
      fh  = (frame_h_cfg == 0) ? 1 : int'(frame_h_cfg);
      // A counter left beyond a lowered frame size counts as the last position.
      eor = (int'(col_pos) + 1 >= fw);
      eof = eor && (int'(row_pos) + 1 >= fh);
      res.pixel = it.pixel;
      for (int p = 0; p < n; p++) begin
        if (!found && key_cfg[p] == it.pixel) begin
          found           = 1'b1;
          res.pixel       = texel_copy[texel_addr(p, int'(tile_r[p]), int'(tile_c[p]))];
          res.substituted = 1'b1;
          res.hit         = p[1:0];
        end
      end
      res.eor = eor;
      res.eof = eof;
      // Every pattern's tile position moves with the raster, in use or not.
      for (int p = 0; p < NumPatternsDefault; p++) begin
        if (eor) begin
          tile_c[p] = '0;
          if (eof || tile_r[p] + 1 >= tile_h[p]) tile_r[p] = '0;
          else tile_r[p] = tile_r[p] + 1'b1;
        end else if (tile_c[p] + 1 >= tile_w[p]) begin
          tile_c[p] = '0;
        end else begin
          tile_c[p] = tile_c[p] + 1'b1;
        end
      end
      if (eor) begin
        col_pos = '0;
        row_pos = eof ? 16'd0 : row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end else if (it.cmd == CMD_UNKNOWN || it.sel >= n) begin
      res.status = 1'b1;
    end else if (it.cmd == CMD_SIZE) begin
      tile_w[it.sel] = clamp_side(it.tile_wd);
      tile_h[it.sel] = clamp_side(it.tile_ht);
      tile_c[it.sel] = '0;
      tile_r[it.sel] = '0;
    end else begin
      // Six-bit texel positions always fall inside a 64 by 64 pattern.
      addr = texel_addr(int'(it.sel), int'(it.row), int'(it.col));
      texel_copy[addr]    = it.pixel;
      texel_written[addr] = 1'b1;
    end
    return res;
  endfunction

  function automatic stim_row_t item_row(logic [1:0] cmd, logic [63:0] pix, logic [1:0] sel,
                                         logic [6:0] tw, logic [6:0] th,
                                         logic [5:0] tc, logic [5:0] tr);
    stim_row_t r;
    r      = '0;
    r.item = {cmd, pix, sel, tw, th, tc, tr};
    return r;
  endfunction

  function automatic stim_row_t known_row(stim_row_t r, fill_res_t res);
    r.has_typed = 1'b1;
    r.typed_res = res;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    stim_row_t r;
    r           = '0;
    r.is_cfg    = 1'b1;
    r.cfg_index = idx;
    r.cfg_data  = data;
    return r;
  endfunction

  function automatic logic [6:0] tile_side_pick();
    if ($urandom_range(0, 7) != 0) return 7'($urandom_range(1, 3));
    case ($urandom_range(0, 2))
      0:       return 7'd0;
      1:       return 7'(SIDE);
      default: return 7'($urandom_range(SIDE + 1, 127));
    endcase
  endfunction

  // Holds the sender back until every predicted result has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (fill_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Applies one row: a register write once the block is idle, or an item
  // presented after a random gap and held until accepted.
  task automatic send_row(stim_row_t r);
    fill_res_t res;
    if (r.is_cfg) begin
      wait_idle();
      cfg_we_i    <= 1'b1;
      cfg_index_i <= r.cfg_index;
      cfg_wdata_i <= r.cfg_data;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      if (r.cfg_index <= CFG_KEY_COLOR_3) key_cfg[r.cfg_index[1:0]] = r.cfg_data;
      else if (r.cfg_index == CFG_PATTERNS_IN_USE) in_use_cfg = r.cfg_data[2:0];
      else if (r.cfg_index == CFG_FRAME_WIDTH) frame_w_cfg = r.cfg_data[15:0];
      else if (r.cfg_index == CFG_FRAME_HEIGHT) frame_h_cfg = r.cfg_data[15:0];
    end else begin
      if (r.item.cmd == CMD_PIXEL) begin
        while (!texel_ready(r.item.pixel)) r.item.pixel = {$urandom, $urandom};
      end
      res = predict_fill(r.item);
      fill_due.push_back(r.has_typed ? r.typed_res : res);
      while ($urandom_range(0, 99) < idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i       <= 1'b1;
      command_i        <= r.item.cmd;
      pixel_value_i    <= r.item.pixel;
      pattern_select_i <= r.item.sel;
      pattern_width_i  <= r.item.tile_wd;
      pattern_height_i <= r.item.tile_ht;
      texel_column_i   <= r.item.col;
      texel_row_i      <= r.item.row;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      items_sent++;
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: every accepted result item is matched with the oldest
  // prediction.
  always @(posedge clk_i) begin : watch_results
    fill_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fill_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got pixel %h",
                 $time, pixel_out_o);
        mismatches++;
      end else begin
        want = fill_due.pop_front();
        check_field("pixel_out",    want.pixel,            pixel_out_o);
        check_field("substituted",  64'(want.substituted), 64'(substituted_o));
        check_field("pattern_hit",  64'(want.hit),         64'(pattern_hit_o));
        check_field("end_of_row",   64'(want.eor),         64'(end_of_row_o));
        check_field("end_of_frame", 64'(want.eof),         64'(end_of_frame_o));
        check_field("status",       64'(want.status),      64'(status_o));
      end
    end
  end

  initial begin
    int          seg_end;
    int          n;
    int          fw;
    int          fh;
    int          in_use;
    logic [63:0] data;
    logic [63:0] pix;

    // Reset values of the state copy; the texel store starts out empty.
    for (int p = 0; p < NumPatternsDefault; p++) begin
      key_cfg[p] = '0;
      tile_w[p]  = 7'd1;
      tile_h[p]  = 7'd1;
      tile_c[p]  = '0;
      tile_r[p]  = '0;
    end
    in_use_cfg  = '0;
    frame_w_cfg = 16'd1;
    frame_h_cfg = 16'd1;
    col_pos     = '0;
    row_pos     = '0;
    foreach (texel_written[i]) texel_written[i] = 1'b0;
    items_sent  = 0;
    mismatches  = 0;
    idle_pct    = 0;
    stall_pct   = 0;

    // Out of reset no key is in use and the frame is one pixel, so every
    // pixel passes and ends both its row and its frame.
    directed_rows.push_back(known_row(item_row(CMD_PIXEL, '0, 0, 0, 0, 0, 0),
                                      {64'd0, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0}));
    directed_rows.push_back(known_row(item_row(CMD_PIXEL, ONES, 0, 0, 0, 0, 0),
                                      {ONES, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0}));
    // With no pattern in use, pattern commands are refused, as is command 3.
    directed_rows.push_back(known_row(item_row(CMD_SIZE, '0, 2'd0, 7'd64, 7'd64, 0, 0),
                                      REJECTED));
    directed_rows.push_back(known_row(item_row(CMD_TEXEL, ONES, 2'd3, 0, 0, 6'd63, 6'd63),
                                      REJECTED));
    directed_rows.push_back(known_row(item_row(CMD_UNKNOWN, ONES, 2'd3, 7'd127, 7'd127,
                                               6'd63, 6'd63), REJECTED));
    // A count of seven acts as four. Frame of two by two.
    directed_rows.push_back(cfg_row(CFG_PATTERNS_IN_USE, 64'd7));
    directed_rows.push_back(cfg_row(CFG_KEY_COLOR_0, '0));
    directed_rows.push_back(cfg_row(CFG_KEY_COLOR_1, ONES));
    directed_rows.push_back(cfg_row(CFG_KEY_COLOR_2, KEY_TWO));
    directed_rows.push_back(cfg_row(CFG_KEY_COLOR_3, KEY_THR));
    directed_rows.push_back(cfg_row(CFG_FRAME_WIDTH, 64'd2));
    directed_rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 64'd2));
    // Tile sizes: zero saturates to one, anything above the side to the side.
    directed_rows.push_back(known_row(item_row(CMD_SIZE, '0, 2'd0, 7'd0, 7'd0, 0, 0), QUIET));
    directed_rows.push_back(known_row(item_row(CMD_SIZE, '0, 2'd1, 7'd127, 7'd65, 0, 0),
                                      QUIET));
    directed_rows.push_back(item_row(CMD_SIZE, '0, 2'd2, 7'd2, 7'd1, 0, 0));
    directed_rows.push_back(item_row(CMD_SIZE, '0, 2'd3, 7'd1, 7'd2, 0, 0));
    directed_rows.push_back(known_row(item_row(CMD_TEXEL, 64'hA0A0_0000_0000_000A, 2'd0,
                                               0, 0, 6'd0, 6'd0), QUIET));
    directed_rows.push_back(item_row(CMD_TEXEL, 64'hB0B0_0000_0000_000B, 2'd1, 0, 0, 0, 0));
    directed_rows.push_back(item_row(CMD_TEXEL, 64'hC0C0_0000_0000_000C, 2'd2, 0, 0, 0, 0));
    directed_rows.push_back(item_row(CMD_TEXEL, 64'hD0D0_0000_0000_000D, 2'd2, 0, 0, 1, 0));
    directed_rows.push_back(item_row(CMD_TEXEL, 64'hE0E0_0000_0000_000E, 2'd3, 0, 0, 0, 0));
    directed_rows.push_back(item_row(CMD_TEXEL, 64'hF0F0_0000_0000_000F, 2'd3, 0, 0, 0, 1));
    directed_rows.push_back(item_row(CMD_TEXEL, ONES, 2'd1, 0, 0, 6'd63, 6'd63));
    // One full frame touching keys zero, two and three, with a pass-through at its end, then key one.
    directed_rows.push_back(item_row(CMD_PIXEL, '0, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(CMD_PIXEL, KEY_TWO, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(CMD_PIXEL, KEY_THR, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(CMD_PIXEL, NON_KEY, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(CMD_PIXEL, ONES, 0, 0, 0, 0, 0));
    // Two keys equal: the lower index wins.
    directed_rows.push_back(cfg_row(CFG_KEY_COLOR_3, '0));
    directed_rows.push_back(item_row(CMD_PIXEL, '0, 0, 0, 0, 0, 0));
    // Only two patterns in use: key two no longer matches and its pattern
    // and pattern three refuse commands.
    directed_rows.push_back(cfg_row(CFG_PATTERNS_IN_USE, 64'd2));
    directed_rows.push_back(item_row(CMD_PIXEL, KEY_TWO, 0, 0, 0, 0, 0));
    directed_rows.push_back(known_row(item_row(CMD_TEXEL, ONES, 2'd2, 0, 0, 6'd5, 6'd5),
                                      REJECTED));
    directed_rows.push_back(known_row(item_row(CMD_SIZE, '0, 2'd3, 7'd4, 7'd4, 0, 0),
                                      REJECTED));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // Two segments per idling mix: none, sender only, receiver only, both.
      case (seg / 2)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 53; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase

      // Keys: often a copy of another key so priority gets exercised.
      for (int k = 0; k < KeyRegs; k++) begin
        case ($urandom_range(0, 7))
          0, 1:    data = key_cfg[$urandom_range(0, KeyRegs - 1)];
          2:       data = '0;
          3:       data = ONES;
          default: data = {$urandom, $urandom};
        endcase
        send_row(cfg_row(CfgIdxW'(CFG_KEY_COLOR_0 + k), data));
      end

      in_use = (seg == 0 || $urandom_range(0, 2) != 0) ? 4 : $urandom_range(0, 7);
      // Frame sizes hit zero and the maximum; a wide frame followed by a
      // narrow one leaves the column counter past the new row end.
      case (seg)
        1:       begin fw = 0;                   fh = 0;                   end
        2:       begin fw = 65535;               fh = $urandom_range(1, 4); end
        3:       begin fw = $urandom_range(1, 4); fh = 65535;               end
        5:       begin fw = 65535;               fh = 65535;               end
        default: begin fw = $urandom_range(1, 8); fh = $urandom_range(1, 8); end
      endcase
      // Bits above a register's width carry random junk.
      data = {$urandom, $urandom};
      data[2:0] = 3'(in_use);
      send_row(cfg_row(CFG_PATTERNS_IN_USE, data));
      data = {$urandom, $urandom};
      data[15:0] = 16'(fw);
      send_row(cfg_row(CFG_FRAME_WIDTH, data));
      data = {$urandom, $urandom};
      data[15:0] = 16'(fh);
      send_row(cfg_row(CFG_FRAME_HEIGHT, data));
      if (seg % 2 == 1) send_row(cfg_row(CFG_SPARE, {$urandom, $urandom}));

      // Pattern setup: a size command, then the texels of the tile. Large
      // tiles get only a sample of texels loaded.
      seg_end = items_sent + SEG_ITEMS;
      n = active_keys();
      for (int p = 0; p < n; p++) begin
        if ($urandom_range(0, 3) != 0) begin
          send_row(item_row(CMD_SIZE, {$urandom, $urandom}, 2'(p), tile_side_pick(),
                            tile_side_pick(), 6'($urandom), 6'($urandom)));
          if (tile_w[p] * tile_h[p] <= 16) begin
            for (int r = 0; r < tile_h[p]; r++) begin
              for (int c = 0; c < tile_w[p]; c++) begin
                send_row(item_row(CMD_TEXEL, {$urandom, $urandom}, 2'(p), 7'($urandom),
                                  7'($urandom), 6'(c), 6'(r)));
              end
            end
          end else begin
            repeat (8) begin
              send_row(item_row(CMD_TEXEL, {$urandom, $urandom}, 2'(p), 7'($urandom),
                                7'($urandom), 6'($urandom_range(0, tile_w[p] - 1)),
                                6'($urandom_range(0, tile_h[p] - 1))));
            end
          end
        end
      end

      // Let the pipeline run dry once before the pixel stream starts.
      wait_idle();

      while (items_sent < seg_end) begin
        if ($urandom_range(0, 99) < 12) begin
          send_row(item_row(2'($urandom_range(0, 3)), {$urandom, $urandom},
                            2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                            7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63))));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: pix = key_cfg[$urandom_range(0, KeyRegs - 1)];
            5:             pix = key_cfg[$urandom_range(0, KeyRegs - 1)]
                                 ^ (64'd1 << $urandom_range(0, 63));
            default:       pix = {$urandom, $urandom};
          endcase
          send_row(item_row(CMD_PIXEL, pix, 2'($urandom_range(0, 3)), 7'($urandom),
                            7'($urandom), 6'($urandom), 6'($urandom)));
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && fill_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ckpf_pkg.sv
rtl/color_key_pattern_fill.sv
sim/testbench.sv
